### rtl/rmth_pkg.sv
// ---------------------------------------------------------------------------
// rmth_pkg: shared types and helpers for the running median block
// Sequencer states, fixed field widths and the heap ordering compare.
// ---------------------------------------------------------------------------
package rmth_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W  = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DN,
    ST_DN_L,
    ST_DN_R,
    ST_UP,
    ST_UP_C,
    ST_DONE
  } rmth_state_t;

  // true if a belongs nearer the root than b
  function automatic logic ahead(input logic signed [SAMPLE_W-1:0] a,
                                 input logic signed [SAMPLE_W-1:0] b,
                                 input logic is_max);
    ahead = is_max ? (a > b) : (a < b);
  endfunction

endpackage

### rtl/rmth_ram.sv
// ---------------------------------------------------------------------------
// rmth_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module rmth_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/running_median_two_heaps.sv
// ---------------------------------------------------------------------------
// running_median_two_heaps: streaming median over two heaps in RAM
// Lower half in a max-heap, upper half in a min-heap; reports twice the median.
// ---------------------------------------------------------------------------
// Each accepted sample word is folded into two heaps held in two RAMs with a
// registered read port. The sample goes through the larger-or-equal heap by a
// replace-top sift-down (skipped when the sample itself is the value that
// moves), and the displaced value is pushed into the other heap by a sift-up.
// A sift-down level steps through a left-child read, a right-child read when
// there is a right child, and a decide (ST_DN, ST_DN_L, ST_DN_R); a sift-up
// level through a parent read and a compare (ST_UP, ST_UP_C). The single RAM
// read port per heap sets this pace.
// One item is in flight at a time: in_stall is high from acceptance until the
// result word is loaded into the output register, which holds it while
// out_stall is high. A full store refuses the sample, flags it and still
// reports the median. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module running_median_two_heaps
  import rmth_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MEDIAN_W-1:0] out_median_doubled,
  output logic [COUNT_W-1:0]         out_stored_count,
  output logic                       out_refused
);

  // heap sizes: lower heap may hold one more than upper
  localparam int LO_DEPTH = (CAPACITY + 1) / 2;
  localparam int UP_DEPTH = CAPACITY / 2;
  localparam int AW       = (LO_DEPTH > 1) ? $clog2(LO_DEPTH) : 1;
  localparam int CW       = $clog2(LO_DEPTH + 1);
  localparam int TW       = $clog2(CAPACITY + 1);

  rmth_state_t state_r, state_nxt;
  logic                       hsel_r, hsel_nxt;    // 1: upper heap is active
  logic signed [SAMPLE_W-1:0] v_r, v_nxt;          // value being placed
  logic signed [SAMPLE_W-1:0] m_r, m_nxt;          // value moving across
  logic [AW-1:0]              i_r, i_nxt;          // hole index
  logic signed [SAMPLE_W-1:0] best_r, best_nxt;    // left child during sift-down
  logic [AW-1:0]              bi_r, bi_nxt;
  logic                       refused_r, refused_nxt;
  logic [CW-1:0]              lo_cnt_r, lo_cnt_nxt, up_cnt_r, up_cnt_nxt;
  logic signed [SAMPLE_W-1:0] lo_top_r, up_top_r;  // mirror of each root

  logic                       out_valid_r;
  logic signed [MEDIAN_W-1:0] out_med_r;
  logic [COUNT_W-1:0]         out_cnt_r;
  logic                       out_ref_r;

  // RAM access
  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic signed [SAMPLE_W-1:0] wdata;
  logic [SAMPLE_W-1:0]        lo_rdata, up_rdata;
  logic signed [SAMPLE_W-1:0] rdata;

  logic                       in_acc, out_load, is_max;
  logic [CW-1:0]              n_cnt;
  logic [AW+1:0]              n_w, l_w, r_w;
  logic [AW-1:0]              p_idx;
  logic [TW-1:0]              total;
  logic signed [MEDIAN_W-1:0] med;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign is_max = !hsel_r;
  assign n_cnt  = hsel_r ? up_cnt_r : lo_cnt_r;
  assign n_w    = (AW + 2)'(n_cnt);
  assign l_w    = {1'b0, i_r, 1'b1};
  assign r_w    = l_w + (AW + 2)'(1);
  assign p_idx  = (i_r - AW'(1)) >> 1;
  assign rdata  = hsel_r ? $signed(up_rdata) : $signed(lo_rdata);
  assign total  = TW'(lo_cnt_r) + TW'(up_cnt_r);

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(LO_DEPTH), .ADDR_W(AW)) u_lo_ram (
    .clk   (clk),
    .we    (we && !hsel_r),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (lo_rdata)
  );

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(UP_DEPTH), .ADDR_W(AW)) u_up_ram (
    .clk   (clk),
    .we    (we && hsel_r),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (up_rdata)
  );

  // sequencer
  always_comb begin
    logic                       dec;
    logic                       go_up;
    logic                       bump;
    logic signed [SAMPLE_W-1:0] cand;
    logic [AW-1:0]              ci;
    dec         = 1'b0;
    go_up       = 1'b0;
    bump        = 1'b0;
    cand        = best_r;
    ci          = bi_r;
    state_nxt   = state_r;
    hsel_nxt    = hsel_r;
    v_nxt       = v_r;
    m_nxt       = m_r;
    i_nxt       = i_r;
    best_nxt    = best_r;
    bi_nxt      = bi_r;
    refused_nxt = refused_r;
    lo_cnt_nxt  = lo_cnt_r;
    up_cnt_nxt  = up_cnt_r;
    we          = 1'b0;
    waddr       = i_r;
    wdata       = v_r;
    raddr       = l_w[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          refused_nxt = 1'b0;
          if (total >= TW'(CAPACITY)) begin
            refused_nxt = 1'b1;
            state_nxt   = ST_DONE;
          end else if (up_cnt_r >= lo_cnt_r) begin
            // upper heap's turn; the smaller of sample and minimum moves down
            if (up_cnt_r != '0 && ahead(up_top_r, in_sample, 1'b0)) begin
              m_nxt     = up_top_r;
              hsel_nxt  = 1'b1;
              v_nxt     = in_sample;
              i_nxt     = '0;
              state_nxt = ST_DN;
            end else begin
              m_nxt     = in_sample;
              hsel_nxt  = 1'b0;
              v_nxt     = in_sample;
              i_nxt     = AW'(lo_cnt_r);
              state_nxt = ST_UP;
            end
          end else begin
            // lower heap's turn; the larger of sample and maximum moves up
            if (ahead(lo_top_r, in_sample, 1'b1)) begin
              m_nxt     = lo_top_r;
              hsel_nxt  = 1'b0;
              v_nxt     = in_sample;
              i_nxt     = '0;
              state_nxt = ST_DN;
            end else begin
              m_nxt     = in_sample;
              hsel_nxt  = 1'b1;
              v_nxt     = in_sample;
              i_nxt     = AW'(up_cnt_r);
              state_nxt = ST_UP;
            end
          end
        end
      end
      ST_DN: begin
        if (l_w >= n_w) begin
          we    = 1'b1;
          go_up = 1'b1;
        end else begin
          raddr     = l_w[AW-1:0];
          state_nxt = ST_DN_L;
        end
      end
      ST_DN_L: begin
        if (r_w < n_w) begin
          best_nxt  = rdata;
          bi_nxt    = l_w[AW-1:0];
          raddr     = r_w[AW-1:0];
          state_nxt = ST_DN_R;
        end else begin
          cand = rdata;
          ci   = l_w[AW-1:0];
          dec  = 1'b1;
        end
      end
      ST_DN_R: begin
        if (ahead(rdata, best_r, is_max)) begin
          cand = rdata;
          ci   = r_w[AW-1:0];
        end
        dec = 1'b1;
      end
      ST_UP: begin
        if (i_r == '0) begin
          we        = 1'b1;
          bump      = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          raddr     = p_idx;
          state_nxt = ST_UP_C;
        end
      end
      ST_UP_C: begin
        we = 1'b1;
        if (ahead(v_r, rdata, is_max)) begin
          wdata     = rdata;
          i_nxt     = p_idx;
          state_nxt = ST_UP;
        end else begin
          bump      = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // move the child nearer the root into the hole, or settle the value there
    if (dec) begin
      we = 1'b1;
      if (ahead(cand, v_r, is_max)) begin
        wdata     = cand;
        i_nxt     = ci;
        state_nxt = ST_DN;
      end else begin
        go_up = 1'b1;
      end
    end

    // hand the displaced value to the other heap
    if (go_up) begin
      hsel_nxt  = !hsel_r;
      v_nxt     = m_r;
      i_nxt     = hsel_r ? AW'(lo_cnt_r) : AW'(up_cnt_r);
      state_nxt = ST_UP;
    end

    if (bump) begin
      if (hsel_r) begin
        up_cnt_nxt = up_cnt_r + CW'(1);
      end else begin
        lo_cnt_nxt = lo_cnt_r + CW'(1);
      end
    end
  end

  // twice the median from the root mirrors
  always_comb begin
    if (lo_cnt_r > up_cnt_r) begin
      med = MEDIAN_W'(lo_top_r) <<< 1;
    end else if (up_cnt_r > lo_cnt_r) begin
      med = MEDIAN_W'(up_top_r) <<< 1;
    end else if (lo_cnt_r != '0) begin
      med = MEDIAN_W'(lo_top_r) + MEDIAN_W'(up_top_r);
    end else begin
      med = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lo_cnt_r    <= '0;
      up_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lo_cnt_r <= lo_cnt_nxt;
      up_cnt_r <= up_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers: no reset
  always_ff @(posedge clk) begin
    hsel_r    <= hsel_nxt;
    v_r       <= v_nxt;
    m_r       <= m_nxt;
    i_r       <= i_nxt;
    best_r    <= best_nxt;
    bi_r      <= bi_nxt;
    refused_r <= refused_nxt;
    // track each root as it is written
    if (we && waddr == '0) begin
      if (hsel_r) begin
        up_top_r <= wdata;
      end else begin
        lo_top_r <= wdata;
      end
    end
    if (out_load) begin
      out_med_r <= med;
      out_cnt_r <= COUNT_W'(total);
      out_ref_r <= refused_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_med_r;
  assign out_stored_count   = out_cnt_r;
  assign out_refused        = out_ref_r;

endmodule

### rtl/rmth_checker.sv
// ---------------------------------------------------------------------------
// rmth_checker: port-level checks for the running median block
// Watches the handshake and result words; bound to the top level.
// ---------------------------------------------------------------------------
module rmth_checker
  import rmth_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [SAMPLE_W-1:0] in_sample,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [MEDIAN_W-1:0] out_median_doubled,
  input logic [COUNT_W-1:0]         out_stored_count,
  input logic                       out_refused
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_median_doubled))
    else $error("result word dropped under stall");

  // one word in flight: block input right after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // refuse only when full
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_refused |-> out_stored_count == COUNT_W'(CAPACITY))
    else $error("refused below capacity");

  // a result always reports a held sample
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stored_count != '0)
    else $error("result with empty store");

endmodule

bind running_median_two_heaps rmth_checker #(.CAPACITY(CAPACITY)) u_rmth_checker (.*);
